// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== src/hcb_pkg.sv =====
// Package of shared types and constants for the Huffman code builder.
package hcb_pkg;
  localparam int IDX_BITS = 4;
  localparam int CODE_BITS = 15;
  localparam int LEN_BITS = 4;
  typedef struct packed {
    logic [15:0] weight;
    logic        last_weight;
  } in_item_t;
  typedef struct packed {
    logic [IDX_BITS-1:0]  symbol_index;
    logic [CODE_BITS-1:0] code_bits;
    logic [LEN_BITS-1:0]  code_length;
    logic                 last_code;
  } out_item_t;
endpackage

// ===== src/hcb_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
interface hcb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/huffman_code_builder.sv =====
// Top level of the Huffman code builder: load, merge, emit sequencer.
//
//  channel | dir | payload
//  in_s    | in  | weight, last_weight
//  out_s   | out | symbol_index, code_bits, code_length, last_code
//
// Weights load at one per cycle. After the last weight, the merge that creates
// node t scans nodes t-1..0 twice through the weight memory port and then writes
// back, for t from n to 2n-2. Each code then walks its parent chain, one node per
// cycle, and holds on the output until it is taken.
// Node weights sit in one RAM; parent links (per-set clear) and left flags are
// flip-flops. Reset is synchronous; a stalled output holds the code walk.
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 16,
  parameter int WEIGHT_BITS = 16
) (
  input logic clk,
  input logic rst,
  hcb_stream_if.sink   in_s,
  hcb_stream_if.source out_s
);
  import hcb_pkg::*;
  localparam int NODES = 2 * MAX_SYMBOLS - 1;
  localparam int NB = $clog2(NODES + 1);
  localparam int WB = WEIGHT_BITS + NB;

  localparam logic [2:0] S_LOAD = 3'd0, S_SCAN = 3'd1, S_WRITE = 3'd2,
                         S_EMIT = 3'd3, S_OUT = 3'd4, S_ONE = 3'd5;
  logic [2:0] state;

  logic [NB-1:0] count, cur, k, best, a, total_node;
  logic          pass, best_set;
  logic [WB-1:0] best_w, a_w;
  logic [NB-1:0] parent [NODES];
  logic [NODES-1:0] is_left, used;
  logic [NB-1:0] sym, walk;
  logic [CODE_BITS-1:0] code;
  logic [LEN_BITS-1:0]  len;
  logic          rd_pending;
  logic [NB-1:0] rd_k;

  // Weight memory.
  logic          we;
  logic [NB-1:0] waddr, raddr;
  logic [WB-1:0] wdata, rdata;
  hcb_ram #(.WIDTH(WB), .DEPTH(1 << NB)) u_wram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign in_s.ready = (state == S_LOAD);
  assign out_s.valid = (state == S_OUT) || (state == S_ONE);
  // Read the node just below k; its data lands next cycle together with rd_k.
  assign raddr = k - 1'b1;

  always_comb begin
    we = 1'b0; waddr = count; wdata = WB'(in_s.data.weight & WB'((64'd1 << WEIGHT_BITS) - 1));
    if (state == S_LOAD && in_s.valid && count < NB'(MAX_SYMBOLS)) we = 1'b1;
    if (state == S_WRITE) begin
      we = 1'b1; waddr = cur; wdata = a_w + best_w;
    end
  end

  always_comb begin
    out_s.data.symbol_index = IDX_BITS'(sym);
    out_s.data.code_bits = (state == S_ONE) ? '0 : code;
    out_s.data.code_length = (state == S_ONE) ? '0 : len;
    out_s.data.last_code = (state == S_ONE) || (sym + 1'b1 == count);
  end

  // Candidate check for the scan: unused, not the first pick on pass 2.
  logic cand;
  assign cand = !used[rd_k] && !(pass && rd_k == a);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; count <= '0; used <= '0; rd_pending <= 1'b0;
      for (int i = 0; i < NODES; i++) parent[i] <= '0;
    end else begin
      unique case (state)
        S_LOAD: if (in_s.valid) begin
          if (count < NB'(MAX_SYMBOLS)) count <= count + 1'b1;
          if (in_s.data.last_weight) begin
            if (count == 0 && MAX_SYMBOLS > 0) begin
              // First weight is the only one.
              count <= NB'(1); sym <= '0; state <= S_ONE;
            end else begin
              cur <= count + 1'b1; total_node <= count + count + 1'b1;
              if (count + 1'b1 == NB'(1)) state <= S_ONE;
              else begin
                k <= count + 1'b1; pass <= 1'b0; best_set <= 1'b0; rd_pending <= 1'b0;
                state <= S_SCAN;
              end
              if (count >= NB'(MAX_SYMBOLS)) begin
                cur <= count; total_node <= count + count - 1'b1; k <= count;
              end
            end
          end
        end
        S_SCAN: begin
          // Issue reads from cur-1 down to 0; evaluate the read issued last cycle.
          rd_pending <= 1'b0;
          if (rd_pending && cand && (!best_set || rdata < best_w)) begin
            best <= rd_k; best_w <= rdata; best_set <= 1'b1;
          end
          if (k != 0) begin
            k <= k - 1'b1; rd_k <= k - 1'b1; rd_pending <= 1'b1;
          end else if (!rd_pending) begin
            if (!pass) begin
              a <= best; a_w <= best_w; pass <= 1'b1; best_set <= 1'b0; k <= cur;
            end else state <= S_WRITE;
          end
        end
        S_WRITE: begin
          used[a] <= 1'b1; used[best] <= 1'b1;
          parent[a] <= cur; parent[best] <= cur;
          is_left[a] <= 1'b1; is_left[best] <= 1'b0;
          if (cur + 1'b1 == total_node) begin
            state <= S_EMIT; sym <= '0; walk <= '0; code <= '0; len <= '0;
          end else begin
            cur <= cur + 1'b1; k <= cur + 1'b1; pass <= 1'b0; best_set <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_EMIT: begin
          // Walk one parent link per cycle.
          if (parent[walk] != '0) begin
            if (!is_left[walk]) code <= code | (CODE_BITS'(1) << len);
            len <= len + 1'b1; walk <= parent[walk];
          end else state <= S_OUT;
        end
        S_OUT: if (out_s.ready) begin
          if (sym + 1'b1 == count) begin
            state <= S_LOAD; count <= '0; used <= '0;
            for (int i = 0; i < NODES; i++) parent[i] <= '0;
          end else begin
            sym <= sym + 1'b1; walk <= sym + 1'b1; code <= '0; len <= '0;
            state <= S_EMIT;
          end
        end
        S_ONE: if (out_s.ready) begin
          state <= S_LOAD; count <= '0;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== src/hcb_ram.sv =====
// Generic single-write, single-read RAM with a registered read.
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/hcb_checker.sv =====
// Port-level checker for the Huffman code builder, bound to the top level.
`include "assert_macros.svh"
module hcb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  `ASSERT_IMPLY(a_no_overlap, clk, rst, out_valid, !in_ready)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_last_done, clk, rst, out_valid && out_ready && out_last, in_ready)
endmodule

bind huffman_code_builder hcb_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_s.valid), .in_ready(in_s.ready),
  .out_valid(out_s.valid), .out_ready(out_s.ready), .out_last(out_s.data.last_code)
);
